### hdl/cfd_pkg.sv
// Package for the custom float decoder: field limits, class codes, register indices and binary64 constants.
// No dependencies.
package cfd_pkg;

    localparam int MAX_EXP_BITS_DEF  = 11;
    localparam int MAX_FRAC_BITS_DEF = 52;

    typedef enum logic [1:0] {
        CLS_NORMAL   = 2'd0,
        CLS_DENORMAL = 2'd1,
        CLS_INFINITY = 2'd2,
        CLS_NAN      = 2'd3
    } value_class_t;

    typedef enum logic [1:0] {
        REG_EXP_WIDTH  = 2'd0,
        REG_FRAC_WIDTH = 2'd1,
        REG_EXP_BIAS   = 2'd2,
        REG_HIDDEN_BIT = 2'd3
    } cfg_index_t;

    localparam logic [63:0] DBL_INF  = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] DBL_QNAN = 64'h7FF8_0000_0000_0000;

endpackage

### hdl/custom_float_decoder.sv
// Custom float decoder top level: splits a raw pattern as a configurable float.
// Depends on cfd_pkg.
//
// Usage:
//   s_axis carries one 64-bit raw pattern per word (sign above exponent above
//   fraction, low-aligned). m_axis returns one decoded word per input word.
//   cfg_* writes one of four registers: 0 exponent width, 1 fraction width,
//   2 exponent bias (signed), 3 hidden bit. Write only while the block is idle.
//   A word accepted on s_axis passes through the input register, then the
//   result register. Throughput: one word per cycle while m_axis is ready, set by
//   the single decode pass between the two registers (field extract, priority
//   encode of the significand, one exponent add and compare).
//   If the receiver stalls, the result register holds; the input register
//   still takes one more word, then s_axis_tready falls until m_axis drains.
//   Reset clears both valid flags and loads the registers with 8, 23, 127, 1.
module custom_float_decoder #(
    parameter int MAX_EXP_BITS  = cfd_pkg::MAX_EXP_BITS_DEF,
    parameter int MAX_FRAC_BITS = cfd_pkg::MAX_FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // [63:0] bit_pattern
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [1:0] value_class, [2] sign_bit, [13:3] stored_exponent,
    // [26:14] true_exponent, [78:27] fraction_field, [142:79] double_bits,
    // [143] range_flag
    output logic [143:0] m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [11:0]  cfg_data
);
    import cfd_pkg::*;

    localparam int EW_W = $clog2(MAX_EXP_BITS + 1);
    localparam int FW_W = $clog2(MAX_FRAC_BITS + 1);

    logic [3:0]  exp_width_reg;
    logic [5:0]  frac_width_reg;
    logic [11:0] exp_bias_reg;
    logic        hidden_reg;

    logic        in_valid_reg;
    logic [63:0] in_data_reg;
    logic        out_valid_reg;
    logic [143:0] out_data_reg;
    logic [143:0] out_data_next;
    logic        in_ready;
    logic        out_load;

    assign cfg_ready     = 1'b1;
    assign out_load      = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign in_ready      = !in_valid_reg || out_load;
    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_width_reg  <= 4'd8;
            frac_width_reg <= 6'd23;
            exp_bias_reg   <= 12'd127;
            hidden_reg     <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_EXP_WIDTH:  exp_width_reg  <= cfg_data[3:0];
                REG_FRAC_WIDTH: frac_width_reg <= cfg_data[5:0];
                REG_EXP_BIAS:   exp_bias_reg   <= cfg_data;
                REG_HIDDEN_BIT: hidden_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input and result valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_ready) in_valid_reg <= s_axis_tvalid;
            if (out_load) out_valid_reg <= 1'b1;
            else if (m_axis_tready) out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_ready && s_axis_tvalid) in_data_reg <= s_axis_tdata;
        if (out_load) out_data_reg <= out_data_next;
    end

    // Decode pass
    logic [EW_W-1:0]  ew;
    logic [FW_W-1:0]  fw;
    logic [63:0]      shifted;
    logic [10:0]      emax;
    logic [10:0]      e;
    logic [51:0]      f;
    logic [51:0]      fmask;
    logic             s;
    logic [52:0]      m;
    logic [5:0]       p;
    logic signed [12:0] te;
    logic signed [14:0] d;
    logic [52:0]      mant_sh;
    logic [63:0]      dbits;
    logic             flag;
    value_class_t     cls;

    always_comb begin
        ew = (exp_width_reg == 4'd0) ? EW_W'(1)
           : (32'(exp_width_reg) > MAX_EXP_BITS) ? EW_W'(MAX_EXP_BITS)
           : EW_W'(exp_width_reg);
        fw = (32'(frac_width_reg) > MAX_FRAC_BITS) ? FW_W'(MAX_FRAC_BITS)
           : FW_W'(frac_width_reg);
        fmask   = ~(52'hF_FFFF_FFFF_FFFF << fw);
        f       = in_data_reg[51:0] & fmask;
        shifted = in_data_reg >> fw;
        emax    = ~(11'h7FF << ew);
        e       = shifted[10:0] & emax;
        s       = shifted[ew];
        dbits   = 64'd0;
        flag    = 1'b0;
        te      = 13'sd0;
        m       = 53'd0;
        p       = 6'd0;
        d       = 15'sd0;
        mant_sh = 53'd0;
        if (e == emax) begin
            cls   = (f != 52'd0) ? CLS_NAN : CLS_INFINITY;
            dbits = (f != 52'd0) ? DBL_QNAN : DBL_INF;
        end else begin
            if (e == 11'd0) begin
                cls = CLS_DENORMAL;
                te  = 13'sd1 - 13'(signed'(exp_bias_reg));
                m   = {1'b0, f};
            end else begin
                cls = CLS_NORMAL;
                te  = signed'({2'b00, e}) - 13'(signed'(exp_bias_reg));
                m   = ({52'd0, hidden_reg} << fw) | {1'b0, f};
            end
            // Priority encode the significand
            for (int i = 0; i < 53; i++) begin
                if (m[i]) p = 6'(i);
            end
            d = 15'(te) - 15'(signed'({9'd0, fw})) + 15'(signed'({9'd0, p}));
            if (m != 53'd0) begin
                if (d > 15'sd1023) begin
                    dbits = DBL_INF;
                    flag  = 1'b1;
                end else if (d < -15'sd1022) begin
                    flag = 1'b1;
                end else begin
                    mant_sh = m << (6'd52 - p);
                    dbits = {1'b0, 11'(d + 15'sd1023), mant_sh[51:0]};
                end
            end
        end
        dbits[63] = s;
        out_data_next = {flag, dbits, f, te, e, s, cls};
    end

endmodule

### verif/custom_float_decoder_test.sv
// Testbench for custom_float_decoder: drives raw patterns under several float formats
// and checks every decoded word against an in-bench predictor. Depends on cfd_pkg.
`timescale 1ns / 1ps

module custom_float_decoder_test;
    import cfd_pkg::*;

    typedef struct packed {
        logic        range_flag;
        logic [63:0] double_bits;
        logic [51:0] fraction_field;
        logic [12:0] true_exponent;
        logic [10:0] stored_exponent;
        logic        sign_bit;
        logic [1:0]  value_class;
    } decoded_t;

    // Scoreboard: predicts each decoded word and checks the results in order
    class decode_board;
        logic [3:0]  exp_w;
        logic [5:0]  frac_w;
        logic [11:0] bias_r;
        logic        hid;
        decoded_t    pending[$];
        int          errors;
        int          checked;

        function new();
            exp_w = 8; frac_w = 23; bias_r = 127; hid = 1;
            errors = 0; checked = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [11:0] v);
            case (idx)
                REG_EXP_WIDTH:  exp_w = v[3:0];
                REG_FRAC_WIDTH: frac_w = v[5:0];
                REG_EXP_BIAS:   bias_r = v;
                REG_HIDDEN_BIT: hid = v[0];
                default: ;
            endcase
        endfunction

        // Work out the decoded word for one accepted pattern
        function void note_pattern(logic [63:0] x);
            int ew, fw, bias, te, p, d;
            logic [63:0] emax, e, f, m, dbits;
            logic s, flag;
            decoded_t r;
            ew = exp_w; fw = frac_w;
            if (ew < 1) ew = 1;
            if (ew > 11) ew = 11;
            if (fw > 52) fw = 52;
            bias = $signed(bias_r);
            emax = (64'd1 << ew) - 1;
            f = x & ((64'd1 << fw) - 1);
            e = (x >> fw) & emax;
            s = x[ew + fw];
            te = 0; flag = 0; dbits = 0;
            if (e == emax) begin
                r.value_class = (f != 0) ? CLS_NAN : CLS_INFINITY;
                dbits = (f != 0) ? DBL_QNAN : DBL_INF;
            end else begin
                if (e == 0) begin
                    r.value_class = CLS_DENORMAL;
                    te = 1 - bias;
                    m = f;
                end else begin
                    r.value_class = CLS_NORMAL;
                    te = int'(e) - bias;
                    m = (64'(hid) << fw) | f;
                end
                if (m != 0) begin
                    p = 0;
                    for (int i = 0; i < 64; i++)
                        if (m[i]) p = i;
                    d = te - fw + p;
                    if (d > 1023) begin
                        dbits = DBL_INF; flag = 1;
                    end else if (d < -1022) begin
                        dbits = 0; flag = 1;
                    end else begin
                        dbits = (64'(d + 1023) << 52)
                              | ((m << (52 - p)) & 64'hF_FFFF_FFFF_FFFF);
                    end
                end
            end
            dbits[63] = dbits[63] | s;
            r.sign_bit = s;
            r.stored_exponent = e[10:0];
            r.true_exponent = te[12:0];
            r.fraction_field = f[51:0];
            r.double_bits = dbits;
            r.range_flag = flag;
            pending.push_back(r);
        endfunction

        function void check_word(decoded_t got);
            decoded_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.value_class !== want.value_class)
                $display("%0t: value_class exp %0d got %0d", $time,
                         want.value_class, got.value_class);
            if (got.sign_bit !== want.sign_bit)
                $display("%0t: sign_bit exp %0d got %0d", $time, want.sign_bit, got.sign_bit);
            if (got.stored_exponent !== want.stored_exponent)
                $display("%0t: stored_exponent exp %h got %h", $time,
                         want.stored_exponent, got.stored_exponent);
            if (got.true_exponent !== want.true_exponent)
                $display("%0t: true_exponent exp %h got %h", $time,
                         want.true_exponent, got.true_exponent);
            if (got.fraction_field !== want.fraction_field)
                $display("%0t: fraction_field exp %h got %h", $time,
                         want.fraction_field, got.fraction_field);
            if (got.double_bits !== want.double_bits)
                $display("%0t: double_bits exp %h got %h", $time,
                         want.double_bits, got.double_bits);
            if (got.range_flag !== want.range_flag)
                $display("%0t: range_flag exp %0d got %0d", $time,
                         want.range_flag, got.range_flag);
            if (got !== want) errors++;
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata = 0;   // [63:0] bit_pattern
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [143:0] m_axis_tdata;       // decoded_t, value_class in the lowest bits
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = 0;
    logic [11:0]  cfg_data = 0;

    decode_board board = new();
    int  hold_off = 0;       // long receiver stall, counted in cycles
    int  formats = 0;

    custom_float_decoder u_top (.*);

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    // Receiver: own stall pattern, plus a long hold-off on request
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            board.check_word(decoded_t'(m_axis_tdata));
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 9) < 3) ? ($time % 400 < 200) : 1'b1;
        end
    end

    task automatic send_word(logic [63:0] x);
        s_axis_tvalid <= 1;
        s_axis_tdata <= x;
        do @(posedge aclk); while (!s_axis_tready);
        board.note_pattern(x);
    endtask

    task automatic idle_sender(int n);
        s_axis_tvalid <= 0;
        s_axis_tdata <= {$urandom, $urandom};
        repeat (n) @(posedge aclk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Hold cfg_valid high; the caller drops it after the last write
    task automatic write_reg(cfg_index_t idx, logic [11:0] v);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        board.set_reg(idx, v);
    endtask

    task automatic set_format(int ew, int fw, int bias, bit h);
        write_reg(REG_EXP_WIDTH, 12'(ew));
        write_reg(REG_FRAC_WIDTH, 12'(fw));
        write_reg(REG_EXP_BIAS, 12'(bias));
        write_reg(REG_HIDDEN_BIT, 12'(h));
        cfg_valid <= 0;
        formats++;
    endtask

    // Random pattern biased towards the special exponent values
    function automatic logic [63:0] shaped_pattern();
        logic [63:0] x;
        int ew, fw, sel;
        ew = board.exp_w; fw = board.frac_w;
        if (ew < 1) ew = 1;
        if (ew > 11) ew = 11;
        if (fw > 52) fw = 52;
        x = {$urandom, $urandom};
        sel = $urandom_range(0, 9);
        if (sel == 0) x &= ~(((64'd1 << ew) - 1) << fw);
        if (sel == 1) x |= ((64'd1 << ew) - 1) << fw;
        if (sel == 2) x &= ~((64'd1 << fw) - 1);
        if (sel == 3) x &= (64'd1 << $urandom_range(0, 63)) - 1;
        return x;
    endfunction

    task automatic random_run(int n);
        int left;
        while (n > 0) begin
            left = $urandom_range(1, 20);
            while (left > 0 && n > 0) begin
                send_word(shaped_pattern());
                left--; n--;
            end
            if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 6));
        end
    endtask

    initial begin
        logic [63:0] directed[$];
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: single precision defaults, then extremes
        directed = '{64'h0, 64'h8000_0000, 64'h3F80_0000, 64'hBF80_0000, 64'h7F80_0000,
                     64'hFF80_0000, 64'h7FC0_0001, 64'h0000_0001, 64'h007F_FFFF,
                     64'h7F7F_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000};
        foreach (directed[i]) send_word(directed[i]);
        drain();
        set_format(11, 52, 2047, 1);   // underflow with the largest widths
        send_word(64'h7FE0_0000_0000_0000);
        send_word(64'h0000_0000_0000_0001);
        send_word(64'hFFFF_FFFF_FFFF_FFFF);
        drain();
        set_format(11, 52, -2048, 1);
        send_word(64'h0010_0000_0000_0000);
        send_word(64'h7FEF_FFFF_FFFF_FFFF);
        drain();
        set_format(0, 63, 0, 0);       // widths out of range, zero bias, no hidden unit
        send_word(64'h0);
        send_word(64'hFFFF_FFFF_FFFF_FFFF);
        send_word(64'h0008_0000_0000_0001);
        send_word(64'h0010_0000_0000_0000);
        drain();
        set_format(15, 0, 1, 1);
        send_word(64'h0);
        send_word(64'h7FF);
        send_word(64'h3FF);
        send_word(64'h400);
        drain();

        // Random formats with long stalls to fill the pipe
        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0: set_format(8, 23, 127, 1);
                1: set_format(5, 10, 15, 1);
                2: set_format(1, 0, 0, 1);
                3: set_format(11, 52, 1023, 1);
                4: set_format(4, 3, 7, 0);
                5: set_format(11, 52, -2048, 1);
                6: set_format(11, 52, 2047, 0);
                default: set_format($urandom_range(0, 15), $urandom_range(0, 63),
                                    $signed(12'($urandom)), $urandom_range(0, 1));
            endcase
            if (ph % 3 == 0) hold_off = 60;
            random_run(140);
            drain();                    // sender pause until every word has come
        end

        repeat (10) @(posedge aclk);
        $display("Covered %0d words over %0d float formats, incl. widths out of range,",
                 board.checked, formats);
        $display("special values, binary64 overflow and underflow, with stalls.");
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
